[src/sacl_pkg.sv]
// sacl_pkg: geometry constants, tag-store row types and helpers for the
// set-associative lru tag store; no dependencies
package sacl_pkg;

    localparam int SETS       = 64;    // power of two
    localparam int WAYS       = 8;
    localparam int LINE_BYTES = 64;
    localparam int ADDR_BITS  = 32;

    localparam int OFS_BITS = $clog2(LINE_BYTES + 1) - 1;   // floor log2
    localparam int IDX_BITS = $clog2(SETS + 1) - 1;
    localparam int TAG_BITS = ADDR_BITS - OFS_BITS - IDX_BITS;
    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_OUT_W = 3;

    localparam logic [WAY_W-1:0] OLDEST_AGE = WAY_W'(WAYS - 1);

    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] tag;
        logic [WAY_W-1:0]    age;
    } t_way_entry;

    typedef t_way_entry [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic                 hit;
        logic [WAY_W-1:0]     way;
        logic                 victim_valid;
        logic [ADDR_BITS-1:0] victim_address;
    } t_lookup;

    // contents of a set that has not been written since reset
    function automatic t_row reset_row();
        t_row r;
        for (int w = 0; w < WAYS; w++) begin
            r[w].valid = 1'b0;
            r[w].tag   = '0;
            r[w].age   = WAY_W'(w);
        end
        return r;
    endfunction

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_BITS-1:0] addr);
        logic [SET_W-1:0] s;
        if (IDX_BITS == 0) begin
            s = '0;
        end else begin
            s = SET_W'(addr >> OFS_BITS);
        end
        return s;
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] addr);
        return TAG_BITS'(addr >> (OFS_BITS + IDX_BITS));
    endfunction

endpackage

[src/sacl_ram.sv]
// sacl_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/sacl_update.sv]
// sacl_update: tag compare, way choice and lru age update for one set row
// depends on sacl_pkg
module sacl_update (
    input  sacl_pkg::t_row                        i_row,
    input  logic [sacl_pkg::TAG_BITS-1:0]         i_tag,
    input  logic [sacl_pkg::SET_W-1:0]            i_set,
    output sacl_pkg::t_row                        o_row,
    output sacl_pkg::t_lookup                     o_lookup
);
    import sacl_pkg::*;

    logic             hit_found, free_found, old_found;
    logic [WAY_W-1:0] hit_way, free_way, old_way, way;
    logic [WAY_W-1:0] ref_age;
    logic             evict;

    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        old_found  = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        old_way    = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit_found && i_row[w].valid && i_row[w].tag == i_tag) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!free_found && !i_row[w].valid) begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
            if (!old_found && i_row[w].age == OLDEST_AGE) begin
                old_found = 1'b1;
                old_way   = WAY_W'(w);
            end
        end

        priority if (hit_found) begin
            way = hit_way;
        end else if (free_found) begin
            way = free_way;
        end else begin
            way = old_way;
        end
        evict   = !hit_found && !free_found;
        ref_age = i_row[way].age;

        // promote chosen way, age the younger ones
        for (int w = 0; w < WAYS; w++) begin
            o_row[w] = i_row[w];
            if (WAY_W'(w) == way) begin
                o_row[w].age = '0;
                if (!hit_found) begin
                    o_row[w].valid = 1'b1;
                    o_row[w].tag   = i_tag;
                end
            end else if (i_row[w].age < ref_age) begin
                o_row[w].age = i_row[w].age + 1'b1;
            end
        end

        o_lookup.hit          = hit_found;
        o_lookup.way          = way;
        o_lookup.victim_valid = evict;
        o_lookup.victim_address = evict
            ? (ADDR_BITS'(i_row[way].tag) << (OFS_BITS + IDX_BITS))
              + (ADDR_BITS'(i_set) << OFS_BITS)
            : '0;
    end

endmodule

[src/set_assoc_cache_lru_tags.sv]
// set_assoc_cache_lru_tags: top level of the lru tag store
// depends on sacl_pkg, sacl_ram and sacl_update
//
// usage
//   request channel: drive i_address and raise start; the word is taken
//   at a rising edge where start is high and busy is low
//   result channel: o_result_valid is high for exactly one cycle and marks
//   o_hit, o_way_used, o_victim_valid, o_victim_address, o_hit_total and
//   o_miss_total; the receiver cannot stall, so the word must be taken then
// timing
//   a request taken at edge n gives its result in the cycle after edge n+1
//   one access every 2 cycles: one cycle for the set read from the row ram,
//   one for compare, lru update and write-back of the row
//   busy is high only during that second cycle, so accesses never overlap
//   in the ram and no forwarding is needed
// reset
//   i_rst_n low (synchronous) clears the counters, the control state and
//   one valid flag per set; a set whose flag is clear reads as all ways
//   invalid, tag zero, age equal to way number, so no clearing pass is run
module set_assoc_cache_lru_tags (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [sacl_pkg::ADDR_BITS-1:0]  i_address,
    output logic                            o_result_valid,
    output logic                            o_hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]  o_way_used,
    output logic                            o_victim_valid,
    output logic [sacl_pkg::ADDR_BITS-1:0]  o_victim_address,
    output logic [sacl_pkg::ADDR_BITS-1:0]  o_hit_total,
    output logic [sacl_pkg::ADDR_BITS-1:0]  o_miss_total
);
    import sacl_pkg::*;

    // control
    logic                 r_busy, r_strobe;
    logic [SETS-1:0]      r_row_ok;            // set written since reset
    // request being worked on
    logic [SET_W-1:0]     r_set;
    logic [TAG_BITS-1:0]  r_tag;
    // result word
    logic                 r_hit, r_victim_valid;
    logic [WAY_W-1:0]     r_way;
    logic [ADDR_BITS-1:0] r_victim_address;
    logic [ADDR_BITS-1:0] r_hit_total, r_miss_total;
    logic [ADDR_BITS-1:0] n_hit_total, n_miss_total;

    logic                 accept;
    logic [ROW_W-1:0]     ram_rdata;
    t_row                 cur_row, new_row;
    t_lookup              lookup;

    assign accept = start && !r_busy;

    // one row per set: all ways' valid, tag and age side by side
    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_busy),
        .i_waddr (r_set),
        .i_wdata (new_row),
        .i_re    (accept),
        .i_raddr (set_of(i_address)),
        .o_rdata (ram_rdata)
    );

    // untouched sets read as their reset contents
    assign cur_row = r_row_ok[r_set] ? t_row'(ram_rdata) : reset_row();

    sacl_update u_update (
        .i_row    (cur_row),
        .i_tag    (r_tag),
        .i_set    (r_set),
        .o_row    (new_row),
        .o_lookup (lookup)
    );

    assign n_hit_total  = r_hit_total + ADDR_BITS'(lookup.hit);
    assign n_miss_total = r_miss_total + ADDR_BITS'(!lookup.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_strobe     <= 1'b0;
            r_row_ok     <= '0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
        end else begin
            r_busy   <= accept;
            r_strobe <= r_busy;
            if (r_busy) begin
                r_row_ok[r_set] <= 1'b1;
                r_hit_total     <= n_hit_total;
                r_miss_total    <= n_miss_total;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= set_of(i_address);
            r_tag <= tag_of(i_address);
        end
        if (r_busy) begin
            r_hit            <= lookup.hit;
            r_way            <= lookup.way;
            r_victim_valid   <= lookup.victim_valid;
            r_victim_address <= lookup.victim_address;
        end
    end

    assign busy             = r_busy;
    assign o_result_valid   = r_strobe;
    assign o_hit            = r_hit;
    assign o_way_used       = WAY_OUT_W'(r_way);
    assign o_victim_valid   = r_victim_valid;
    assign o_victim_address = r_victim_address;
    assign o_hit_total      = r_hit_total;
    assign o_miss_total     = r_miss_total;

    // a taken word always occupies exactly one work cycle
    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("taken word did not start work");

    a_victim_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_victim_valid) |-> !r_hit)
        else $error("eviction reported on a hit");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (ADDR_BITS'(r_hit_total + r_miss_total)
                    == ADDR_BITS'($past(r_hit_total + r_miss_total) + 1'b1)))
        else $error("hit and miss totals did not advance by one");

endmodule

[bench/testbench.sv]
// testbench: self-checking bench for the lru tag store set_assoc_cache_lru_tags
// depends on sacl_pkg for the geometry; keeps its own copy of tags, valid bits and ages
module testbench;
    import sacl_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int LIMIT_CYCLES = 200000;
    localparam int LINE_SHIFT   = OFS_BITS;
    localparam int TAG_SHIFT    = OFS_BITS + IDX_BITS;

    // one expected lookup result, field for field as on the result ports
    typedef struct {
        logic                   hit;
        logic [WAY_OUT_W-1:0]   way_used;
        logic                   victim_valid;
        logic [ADDR_BITS-1:0]   victim_address;
        logic [ADDR_BITS-1:0]   hit_total;
        logic [ADDR_BITS-1:0]   miss_total;
    } t_lookup_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [ADDR_BITS-1:0]   i_address;
    logic                   o_result_valid;
    logic                   o_hit;
    logic [WAY_OUT_W-1:0]   o_way_used;
    logic                   o_victim_valid;
    logic [ADDR_BITS-1:0]   o_victim_address;
    logic [ADDR_BITS-1:0]   o_hit_total;
    logic [ADDR_BITS-1:0]   o_miss_total;

    // shadow tag store
    logic [TAG_BITS-1:0]    shadow_tag   [SETS][WAYS];
    logic                   shadow_valid [SETS][WAYS];
    int unsigned            shadow_age   [SETS][WAYS];
    logic [ADDR_BITS-1:0]   shadow_hits;
    logic [ADDR_BITS-1:0]   shadow_misses;

    t_lookup_result         pending_lookups[$];
    int unsigned            mismatch_count;
    int unsigned            cycle_count;
    int unsigned            sender_idle_pct;

    set_assoc_cache_lru_tags u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_address        (i_address),
        .o_result_valid   (o_result_valid),
        .o_hit            (o_hit),
        .o_way_used       (o_way_used),
        .o_victim_valid   (o_victim_valid),
        .o_victim_address (o_victim_address),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // cleared shadow store, same as the block after reset
    task automatic clear_shadow();
        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                shadow_tag[s][w]   = '0;
                shadow_valid[s][w] = 1'b0;
                shadow_age[s][w]   = w;
            end
        end
        shadow_hits   = '0;
        shadow_misses = '0;
    endtask

    // make way the youngest, ageing every way that was younger than it
    function automatic void make_youngest(input int unsigned set_idx, input int unsigned way);
        int unsigned old_age;
        old_age = shadow_age[set_idx][way];
        for (int w = 0; w < WAYS; w++) begin
            if (shadow_age[set_idx][w] < old_age) shadow_age[set_idx][w]++;
        end
        shadow_age[set_idx][way] = 0;
    endfunction

    // lru lookup on the shadow store: hit, first free way, or evict the oldest way
    function automatic t_lookup_result lru_lookup(input logic [ADDR_BITS-1:0] addr);
        t_lookup_result      res;
        int unsigned         set_idx;
        logic [TAG_BITS-1:0] tag;
        int unsigned         way;
        bit                  found;
        set_idx = (addr >> LINE_SHIFT) % SETS;
        tag     = TAG_BITS'(addr >> TAG_SHIFT);
        way     = 0;
        found   = 1'b0;
        res.hit            = 1'b0;
        res.victim_valid   = 1'b0;
        res.victim_address = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
                found = 1'b1;
                way   = w;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            shadow_hits++;
            make_youngest(set_idx, way);
        end else begin
            shadow_misses++;
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !shadow_valid[set_idx][w]) begin
                    found = 1'b1;
                    way   = w;
                end
            end
            // full set: evict whichever way has the oldest age
            if (!found) begin
                for (int w = WAYS - 1; w >= 0; w--) begin
                    if (shadow_age[set_idx][w] == WAYS - 1) way = w;
                end
                res.victim_valid   = 1'b1;
                res.victim_address = (ADDR_BITS'(shadow_tag[set_idx][way]) << TAG_SHIFT)
                                   + (ADDR_BITS'(set_idx) << LINE_SHIFT);
            end
            make_youngest(set_idx, way);
            shadow_valid[set_idx][way] = 1'b1;
            shadow_tag[set_idx][way]   = tag;
        end
        res.way_used   = WAY_OUT_W'(way);
        res.hit_total  = shadow_hits;
        res.miss_total = shadow_misses;
        return res;
    endfunction

    function automatic logic [ADDR_BITS-1:0] line_address(input logic [ADDR_BITS-1:0] tag,
                                                          input int unsigned set_idx,
                                                          input logic [ADDR_BITS-1:0] offset);
        return (tag << TAG_SHIFT) | (ADDR_BITS'(set_idx % SETS) << LINE_SHIFT)
             | (offset & ADDR_BITS'(LINE_BYTES - 1));
    endfunction

    task automatic report_mismatch(input string field, input logic [ADDR_BITS-1:0] got,
                                   input logic [ADDR_BITS-1:0] want);
        $display("mismatch at cycle %0d: %s got 0x%08h want 0x%08h",
                 cycle_count, field, got, want);
        mismatch_count++;
    endtask

    // send one address word; start stays high into the next word unless the sender idles
    task automatic issue_access(input logic [ADDR_BITS-1:0] addr);
        t_lookup_result next_lookup;
        start     <= 1'b1;
        i_address <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        next_lookup = lru_lookup(addr);
        pending_lookups.insert(pending_lookups.size(), next_lookup);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start     <= 1'b0;
            i_address <= $urandom;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // result checker: every strobed word against the oldest expectation
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("unexpected result, address", o_victim_address, '0);
            end else begin
                want = pending_lookups.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch("hit", ADDR_BITS'(o_hit), ADDR_BITS'(want.hit));
                if (o_way_used !== want.way_used)
                    report_mismatch("way_used", ADDR_BITS'(o_way_used),
                                    ADDR_BITS'(want.way_used));
                if (o_victim_valid !== want.victim_valid)
                    report_mismatch("victim_valid", ADDR_BITS'(o_victim_valid),
                                    ADDR_BITS'(want.victim_valid));
                if (o_victim_address !== want.victim_address)
                    report_mismatch("victim_address", o_victim_address, want.victim_address);
                if (o_hit_total !== want.hit_total)
                    report_mismatch("hit_total", o_hit_total, want.hit_total);
                if (o_miss_total !== want.miss_total)
                    report_mismatch("miss_total", o_miss_total, want.miss_total);
            end
        end
    end

    // lowest and highest addresses, hits on other offsets of the same line
    task automatic test_address_extremes();
        sender_idle_pct = 30;
        issue_access(32'h0000_0000);
        issue_access(32'h0000_003f);
        issue_access(32'hffff_ffff);
        issue_access(32'hffff_ffc0);
        issue_access(32'haaaa_aaaa);
        issue_access(32'h5555_5555);
    endtask

    // fill one set to the last way, hit its oldest and a middle line, then evict twice
    task automatic test_fill_and_evict();
        logic [ADDR_BITS-1:0] fill_tags [WAYS];
        sender_idle_pct = 0;
        for (int w = 0; w < WAYS; w++) fill_tags[w] = w;
        fill_tags[WAYS-1] = (1 << TAG_BITS) - 1;
        for (int w = 0; w < WAYS; w++) issue_access(line_address(fill_tags[w], 5, $urandom));
        issue_access(line_address(fill_tags[0], 5, 0));
        issue_access(line_address(fill_tags[WAYS/2], 5, LINE_BYTES - 1));
        // tag 1 is now the oldest, the refill of tag 1 then pushes out tag 2
        issue_access(line_address(WAYS + 100, 5, 7));
        issue_access(line_address(fill_tags[1], 5, 9));
        issue_access(line_address(fill_tags[1], 5, 0));
    endtask

    // mostly a handful of hot sets and tags so hits and evictions are common,
    // with fully random addresses mixed in for the remaining words
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned words);
        logic [ADDR_BITS-1:0] tag_base;
        int unsigned          hot_set;
        logic [ADDR_BITS-1:0] addr;
        sender_idle_pct = idle_pct;
        tag_base = $urandom & ((1 << TAG_BITS) - 1);
        hot_set  = $urandom_range(0, SETS - 1);
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(99) < 75) begin
                addr = line_address(tag_base ^ $urandom_range(0, WAYS + 4),
                                    hot_set + $urandom_range(0, 3), $urandom);
            end else begin
                addr = $urandom;
            end
            issue_access(addr);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_address       = '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        clear_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_address_extremes();
        test_fill_and_evict();
        test_random_traffic(30, 300);
        test_random_traffic(63, 300);
        test_random_traffic(0, 300);

        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
